/* design/segment_table_translator_unit_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SEGMENT_TABLE_TRANSLATOR_UNIT_MACROS_SVH
`define SEGMENT_TABLE_TRANSLATOR_UNIT_MACROS_SVH

// Clocked on clk_i, off while rst_ni is low.
`define STT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, written as an antecedent and an overlapping consequent.
`define STT_ASSERT_IMPL(label, ante, cons, msg) \
  `STT_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* design/stt_pkg.sv */
package stt_pkg;

  localparam int NUM_SEGMENTS_DEF = 8;

  localparam int ACTION_W = 2;
  localparam int IDX_W    = 4;
  localparam int OFF_W    = 32;
  localparam int BASE_W   = 32;
  localparam int LEN_W    = 31;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 32;

  localparam int IN_FIELDS_W  = IDX_W + OFF_W + BASE_W + LEN_W;
  localparam int OUT_FIELDS_W = ADDR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int ENTRY_W = LEN_W + BASE_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TRANSLATE = 2'd0,
    ACT_SET       = 2'd1,
    ACT_ALLOC     = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_INDEX    = 2'd1,
    ST_NOT_PRESENT  = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [BASE_W-1:0] base;
  } entry_t;

  typedef struct packed {
    action_e           action;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  offset;
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

/* design/stt_ram.sv */
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/segment_table_translator_unit.sv */
// Segment table translator.
// Input stream (s_axis_*): one transaction carries the action (translate, set
// entry, allocate entry at the bump pointer) in tuser, and a segment index, an
// offset, a base and a length in tdata. Output stream (m_axis_*): one
// transaction per input, status code in tuser and address in tdata, in order.
// Entries live in a one-port-read, one-port-write RAM with registered read;
// valid marks and the bump pointer are flip-flops.
// Throughput: one transaction per cycle unless m_axis stalls. The RAM read is
// issued at accept and the result (and any table write) commits once the output
// register is free; a read of the entry being written in that same cycle is
// served from a forwarding register.
// Reset clears all valid marks, the bump pointer and both stream stages; the
// table is usable on the first cycle after reset.
// When m_axis_tready is low, the result is held in the output register, one
// more item may sit in the lookup stage, and s_axis_tready drops until the
// output register drains.
module segment_table_translator_unit #(
  parameter int NUM_SEGMENTS = stt_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // segment_index, offset, base_address, segment_length, zero pad
  input  logic [stt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [stt_pkg::ACTION_W-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // address
  output logic [stt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [stt_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int AW    = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int CMP_W = stt_pkg::IDX_W + 1;

  stt_pkg::item_t  in_item;
  stt_pkg::item_t  item_q;
  stt_pkg::entry_t entry;
  stt_pkg::entry_t wr_entry;
  stt_pkg::entry_t ram_rdata;
  stt_pkg::entry_t fwd_entry_q, fwd_entry_d;
  stt_pkg::status_e status;

  logic                         busy_q, busy_d;
  logic                         fwd_q, fwd_d;
  logic [NUM_SEGMENTS-1:0]      valid_q, valid_d;
  logic [stt_pkg::ADDR_W-1:0]   ptr_q, ptr_d;
  logic                         m_valid_q, m_valid_d;
  logic [stt_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [stt_pkg::STATUS_W-1:0] m_user_q, m_user_d;
  logic [stt_pkg::ADDR_W-1:0]   addr;
  logic                         out_free, commit, in_acc, idx_ok, wr, is_write;
  logic [AW-1:0]                idx_a;

  assign in_item.action = stt_pkg::action_e'(s_axis_tuser);
  assign in_item.idx    = s_axis_tdata[3:0];
  assign in_item.offset = s_axis_tdata[35:4];
  assign in_item.base   = s_axis_tdata[67:36];
  assign in_item.len    = s_axis_tdata[98:68];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = busy_q && out_free;
  assign s_axis_tready = !busy_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  stt_ram #(
    .WIDTH (stt_pkg::ENTRY_W),
    .DEPTH (NUM_SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (idx_a),
    .wdata_i (wr_entry),
    .re_i    (in_acc),
    .raddr_i (in_item.idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign idx_a    = item_q.idx[AW-1:0];
  assign idx_ok   = {1'b0, item_q.idx} < CMP_W'(NUM_SEGMENTS);
  assign entry    = fwd_q ? fwd_entry_q : ram_rdata;
  assign is_write = (item_q.action == stt_pkg::ACT_SET) ||
                    (item_q.action == stt_pkg::ACT_ALLOC);
  assign wr       = commit && idx_ok && is_write;

  assign wr_entry.len  = item_q.len;
  assign wr_entry.base = (item_q.action == stt_pkg::ACT_ALLOC) ? ptr_q : item_q.base;

  always_comb begin
    status = stt_pkg::ST_OK;
    addr   = '0;
    case (item_q.action)
      stt_pkg::ACT_NONE: begin
        status = stt_pkg::ST_OK;
      end
      stt_pkg::ACT_SET: begin
        if (!idx_ok) status = stt_pkg::ST_BAD_INDEX;
      end
      stt_pkg::ACT_ALLOC: begin
        if (!idx_ok) status = stt_pkg::ST_BAD_INDEX;
        else addr = ptr_q;
      end
      stt_pkg::ACT_TRANSLATE: begin
        if (!idx_ok) begin
          status = stt_pkg::ST_BAD_INDEX;
        end else if (!valid_q[idx_a]) begin
          status = stt_pkg::ST_NOT_PRESENT;
        end else if (item_q.offset[stt_pkg::OFF_W-1] ||
                     (item_q.offset >= {1'b0, entry.len})) begin
          status = stt_pkg::ST_OUT_OF_RANGE;
        end else begin
          addr = entry.base + item_q.offset;
        end
      end
      default: begin
        status = stt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    fwd_d       = fwd_q;
    fwd_entry_d = fwd_entry_q;
    valid_d     = valid_q;
    ptr_d       = ptr_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    if (commit) begin
      busy_d    = 1'b0;
      m_valid_d = 1'b1;
      m_data_d  = addr;
      m_user_d  = status;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (wr) begin
      valid_d[idx_a] = 1'b1;
      if (item_q.action == stt_pkg::ACT_ALLOC) begin
        ptr_d = ptr_q + {1'b0, item_q.len};
      end
    end
    if (in_acc) begin
      busy_d      = 1'b1;
      fwd_d       = wr && (in_item.idx[AW-1:0] == idx_a);
      fwd_entry_d = wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      fwd_q     <= 1'b0;
      valid_q   <= '0;
      ptr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      fwd_q     <= fwd_d;
      valid_q   <= valid_d;
      ptr_q     <= ptr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_entry_q <= fwd_entry_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
    if (in_acc) begin
      item_q <= in_item;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

/* design/stt_checker.sv */
`include "segment_table_translator_unit_macros.svh"

module stt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [stt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [stt_pkg::STATUS_W-1:0]   m_axis_tuser
);

  logic in_fire;
  logic fault;
  logic stall;
  logic [stt_pkg::STATUS_W+stt_pkg::OUT_DATA_W-1:0] out_word;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign fault    = m_axis_tuser != stt_pkg::ST_OK;
  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign out_word = {m_axis_tuser, m_axis_tdata};

  `STT_ASSERT(a_out_hold, stall |=> m_axis_tvalid, "result dropped while stalled")
  `STT_ASSERT(a_data_hold, stall |=> $stable(out_word), "result changed while stalled")
  `STT_ASSERT_IMPL(a_fault_zero, m_axis_tvalid && fault, m_axis_tdata == '0, "fault with address")
  `STT_ASSERT_IMPL(a_latency, $rose(m_axis_tvalid), $past(in_fire, 2), "result without transaction")

endmodule

bind segment_table_translator_unit stt_checker u_stt_checker (.*);

/* tb/segment_table_translator_unit_test.sv */
module segment_table_translator_unit_test;

  localparam int NSEG         = stt_pkg::NUM_SEGMENTS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    stt_pkg::status_e             status;
    logic [stt_pkg::ADDR_W-1:0]   addr;
  } xlat_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [stt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [stt_pkg::ACTION_W-1:0]   s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [stt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [stt_pkg::STATUS_W-1:0]   m_axis_tuser;

  // shadow segment table
  logic [stt_pkg::BASE_W-1:0] seg_base  [NSEG];
  logic [stt_pkg::LEN_W-1:0]  seg_len   [NSEG];
  logic                       seg_valid [NSEG];
  logic [stt_pkg::ADDR_W-1:0] bump_ptr;

  xlat_result_t pending_q[$];
  int           mismatch_cnt = 0;
  int           accepted_cnt = 0;
  int           status_cnt [4] = '{0, 0, 0, 0};
  int           cycle_cnt = 0;
  int           burst_left = 0;
  bit           steady = 1'b0;

  segment_table_translator_unit #(.NUM_SEGMENTS(NSEG)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic xlat_result_t apply_segment_op(stt_pkg::action_e act,
                                                    logic [stt_pkg::IDX_W-1:0] idx,
                                                    logic [stt_pkg::OFF_W-1:0] off,
                                                    logic [stt_pkg::BASE_W-1:0] base,
                                                    logic [stt_pkg::LEN_W-1:0] len);
    xlat_result_t r;
    r.status = stt_pkg::ST_OK;
    r.addr   = '0;
    if (act == stt_pkg::ACT_NONE) begin
    end else if (idx >= NSEG) begin
      r.status = stt_pkg::ST_BAD_INDEX;
    end else if (act == stt_pkg::ACT_SET) begin
      seg_base[idx]  = base;
      seg_len[idx]   = len;
      seg_valid[idx] = 1'b1;
    end else if (act == stt_pkg::ACT_ALLOC) begin
      r.addr         = bump_ptr;
      seg_base[idx]  = bump_ptr;
      seg_len[idx]   = len;
      seg_valid[idx] = 1'b1;
      bump_ptr       = bump_ptr + {1'b0, len};
    end else begin
      if (!seg_valid[idx]) begin
        r.status = stt_pkg::ST_NOT_PRESENT;
      end else if (off[stt_pkg::OFF_W-1] || off >= {1'b0, seg_len[idx]}) begin
        r.status = stt_pkg::ST_OUT_OF_RANGE;
      end else begin
        r.addr = seg_base[idx] + off;
      end
    end
    return r;
  endfunction

  task automatic send_op(input stt_pkg::action_e act, input logic [stt_pkg::IDX_W-1:0] idx,
                         input logic [stt_pkg::OFF_W-1:0] off,
                         input logic [stt_pkg::BASE_W-1:0] base,
                         input logic [stt_pkg::LEN_W-1:0] len);
    logic [stt_pkg::IN_DATA_W-1:0] word;
    xlat_result_t                  r;
    word = stt_pkg::IN_DATA_W'({len, base, off, idx});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_segment_op(act, idx, off, base, len);
    pending_q = {pending_q, r};
    accepted_cnt++;
    status_cnt[r.status]++;
    if (!steady) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker and downstream backpressure
  always @(posedge clk_i) begin
    xlat_result_t               exp_r;
    stt_pkg::status_e           got_status;
    logic [stt_pkg::ADDR_W-1:0] got_addr;
    static int rx_left = 0;
    static int rx_mode = 0;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = stt_pkg::status_e'(m_axis_tuser);
      got_addr   = m_axis_tdata[stt_pkg::ADDR_W-1:0];
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected transaction: status=%0d addr=%h", got_status, got_addr);
      end else begin
        exp_r = pending_q.pop_front();
        if (got_status !== exp_r.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("status mismatch: expected %0d, got %0d", exp_r.status, got_status);
        end
        if (got_addr !== exp_r.addr) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("address mismatch: expected %h, got %h", exp_r.addr, got_addr);
        end
      end
    end
    if (rx_left == 0) begin
      rx_left = $urandom_range(8, 200);
      rx_mode = $urandom_range(0, 3);
    end
    rx_left--;
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((rx_left % 24) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("segment_table_translator_unit_test: done, errors");
      $finish;
    end
  end

  task automatic test_index_faults();
    send_op(stt_pkg::ACT_TRANSLATE, 4'd15, 32'h0, 32'h0, 31'd1);
    send_op(stt_pkg::ACT_SET, 4'(NSEG), 32'h0, 32'hDEAD_BEEF, 31'd100);
    send_op(stt_pkg::ACT_ALLOC, 4'd12, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_op(stt_pkg::ACT_NONE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
  endtask

  task automatic test_not_present();
    send_op(stt_pkg::ACT_TRANSLATE, 4'd0, 32'h0, 32'h0, 31'd0);
    send_op(stt_pkg::ACT_TRANSLATE, 4'(NSEG - 1), 32'h1, 32'h0, 31'd0);
  endtask

  task automatic test_set_and_bounds();
    send_op(stt_pkg::ACT_SET, 4'd0, 32'h0, 32'hFFFF_FFF0, 31'h7FFF_FFFF);
    send_op(stt_pkg::ACT_TRANSLATE, 4'd0, 32'h0, 32'h0, 31'd0);
    send_op(stt_pkg::ACT_TRANSLATE, 4'd0, 32'h7FFF_FFFE, 32'h0, 31'd0);   // wraps past 2^32
    send_op(stt_pkg::ACT_TRANSLATE, 4'd0, 32'h7FFF_FFFF, 32'h0, 31'd0);   // offset == length
    send_op(stt_pkg::ACT_TRANSLATE, 4'd0, 32'hFFFF_FFFF, 32'h0, 31'd0);   // negative
    send_op(stt_pkg::ACT_TRANSLATE, 4'd0, 32'h8000_0000, 32'h0, 31'd0);
  endtask

  task automatic test_alloc_and_wrap();
    send_op(stt_pkg::ACT_ALLOC, 4'd1, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_op(stt_pkg::ACT_ALLOC, 4'd2, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_op(stt_pkg::ACT_ALLOC, 4'd3, 32'h0, 32'h0, 31'd2);
    send_op(stt_pkg::ACT_ALLOC, 4'd4, 32'h0, 32'h0, 31'd0);
    send_op(stt_pkg::ACT_TRANSLATE, 4'd4, 32'h0, 32'h0, 31'd0);          // zero length
    send_op(stt_pkg::ACT_ALLOC, 4'd1, 32'h0, 32'hFFFF_FFFF, 31'd5);       // overwrite
    send_op(stt_pkg::ACT_TRANSLATE, 4'd1, 32'd4, 32'h0, 31'd0);
    send_op(stt_pkg::ACT_SET, 4'd2, 32'h0, 32'h1234_5678, 31'd16);        // overwrite
    send_op(stt_pkg::ACT_TRANSLATE, 4'd2, 32'd15, 32'h0, 31'd0);
  endtask

  task automatic test_unused_action();
    send_op(stt_pkg::ACT_NONE, 4'd0, $urandom(), $urandom(), 31'($urandom()));
  endtask

  task automatic random_ops(input int count);
    stt_pkg::action_e           act;
    logic [stt_pkg::IDX_W-1:0]  idx;
    logic [stt_pkg::OFF_W-1:0]  off;
    logic [stt_pkg::BASE_W-1:0] base;
    logic [stt_pkg::LEN_W-1:0]  len;
    logic [stt_pkg::OFF_W-1:0]  cur_len;
    int                         r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) act = stt_pkg::ACT_TRANSLATE;
      else if (r < 72) act = stt_pkg::ACT_SET;
      else if (r < 90) act = stt_pkg::ACT_ALLOC;
      else act = stt_pkg::ACT_NONE;
      if ($urandom_range(0, 9) == 0) idx = 4'($urandom_range(NSEG, 15));
      else idx = 4'($urandom_range(0, NSEG - 1));
      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = '1;
        2, 3, 4, 5: len = 31'($urandom_range(1, 64));
        6, 7: len = 31'($urandom_range(1, 65536));
        default: len = 31'($urandom());
      endcase
      if ($urandom_range(0, 4) == 0) base = 32'hFFFF_FF00 + $urandom_range(0, 255);
      else base = $urandom();
      cur_len = (idx < NSEG) ? {1'b0, seg_len[idx]} : 32'd0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: off = (cur_len != 0) ? $urandom_range(0, cur_len - 1) : 32'd0;
        6: off = cur_len - 1;
        7: off = cur_len;
        8: off = {1'b1, 31'($urandom())};
        default: off = $urandom();
      endcase
      send_op(act, idx, off, base, len);
    end
  endtask

  task automatic test_random_traffic();
    random_ops(600);
    wait_idle();
    steady = 1'b1;
    random_ops(200);
    steady = 1'b0;
    random_ops(900);
  endtask

  initial begin
    for (int i = 0; i < NSEG; i++) begin
      seg_base[i]  = '0;
      seg_len[i]   = '0;
      seg_valid[i] = 1'b0;
    end
    bump_ptr = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_index_faults();
    test_not_present();
    test_set_and_bounds();
    test_alloc_and_wrap();
    test_unused_action();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d transactions checked in order under random gaps and backpressure",
             accepted_cnt);
    $display("statuses: ok %0d, bad index %0d, not present %0d, out of range %0d",
             status_cnt[stt_pkg::ST_OK], status_cnt[stt_pkg::ST_BAD_INDEX],
             status_cnt[stt_pkg::ST_NOT_PRESENT], status_cnt[stt_pkg::ST_OUT_OF_RANGE]);
    if (mismatch_cnt == 0) begin
      $display("segment_table_translator_unit_test: done, clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("segment_table_translator_unit_test: done, errors");
    end
    $finish;
  end

endmodule
